// ===== hw/rtl/itda_pkg.sv =====
package itda_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	// width of one BCD digit
	localparam int DIGIT_W = 4;

	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;

endpackage

// ===== hw/rtl/itda_dabble.sv =====
// One shift-add-3 step: adjust every BCD digit, then shift in the next binary bit.
module itda_dabble import itda_pkg::*; #(
	parameter int NUM_DIGITS = 10
) (
	input  logic [NUM_DIGITS*DIGIT_W-1:0] bcd,
	input  logic                          bit_in,
	output logic [NUM_DIGITS*DIGIT_W-1:0] bcd_next
);

	logic [NUM_DIGITS*DIGIT_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			end else begin
				adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	assign bcd_next = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_in};

endmodule

// ===== hw/rtl/integer_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text.
// Input channel: in_valid / in_stall carries one two's-complement value per word.
// Output channel: out_valid / out_stall carries one character per word, most
// significant first; a negative value starts with '-', zero gives a single '0',
// and last marks the final character of each number.
// One value at a time: in_stall stays high from acceptance until the final
// character has been loaded into the output register.
// Sequence: shift-add-3 conversion of all VALUE_WIDTH bits (one input bit per cycle
// through the shared adjust unit), then the skip of leading zero digits, then the
// characters, one per cycle while the receiver does not stall.
// The output register lets the next value be accepted while the final
// character still waits. When the receiver stalls, the output word holds and
// the sequencer waits for it before loading another character.
// Reset clears the sequencer and the output valid; no word is in flight after.
module integer_to_decimal_ascii import itda_pkg::*; #(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [VALUE_WIDTH-1:0] value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             char_code,
	output logic                   last
);

	// decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude
	localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
	localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
	localparam int PTR_W      = $clog2(NUM_DIGITS);
	localparam int CNT_W      = $clog2(VALUE_WIDTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SKIP = 3'd2;
	localparam logic [2:0] S_SIGN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]             state_q;
	logic                   neg_q;
	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_next;
	logic [CNT_W-1:0]       cnt_q;
	logic [PTR_W-1:0]       ptr_q;
	logic [DIGIT_W-1:0]     cur_digit;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic                   out_free;
	logic                   in_acc;

	itda_dabble #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_dabble (
		.bcd     (bcd_q),
		.bit_in  (bin_q[VALUE_WIDTH-1]),
		.bcd_next(bcd_next)
	);

	assign cur_digit = bcd_q[{ptr_q, 2'b00} +: DIGIT_W];
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && (state_q == S_IDLE);

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last      = last_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= S_CONV;
				S_CONV: if (cnt_q == '0) state_q <= S_SKIP;
				S_SKIP: begin
					if (ptr_q == '0 || cur_digit != '0) begin
						state_q <= neg_q ? S_SIGN : S_EMIT;
					end
				end
				S_SIGN: if (out_free) state_q <= S_EMIT;
				S_EMIT: if (out_free && ptr_q == '0) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			neg_q <= value[VALUE_WIDTH-1];
			bin_q <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
			bcd_q <= '0;
			cnt_q <= CNT_W'(VALUE_WIDTH - 1);
			ptr_q <= PTR_W'(NUM_DIGITS - 1);
		end else if (state_q == S_CONV) begin
			bcd_q <= bcd_next;
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (state_q == S_SKIP) begin
			if (ptr_q != '0 && cur_digit == '0) ptr_q <= ptr_q - PTR_W'(1);
		end else if (state_q == S_EMIT && out_free && ptr_q != '0) begin
			ptr_q <= ptr_q - PTR_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == S_SIGN) || (state_q == S_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_SIGN) begin
				char_q <= CH_MINUS;
				last_q <= 1'b0;
			end else if (state_q == S_EMIT) begin
				char_q <= CH_ZERO + {4'b0000, cur_digit};
				last_q <= (ptr_q == '0);
			end
		end
	end

endmodule

// ===== sim/integer_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

module integer_to_decimal_ascii_tb;
	import itda_pkg::*;

	localparam int VW = 32;
	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 300;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} char_word_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	class ascii_scoreboard;
		char_word_t  text_q[$];
		int unsigned mismatches;
		int unsigned chars_checked;
		int unsigned numbers_noted;
		logic [10:1] seen_pos = '0;
		logic [10:1] seen_neg = '0;

		function void note_value(logic [VW-1:0] v);
			logic [VW-1:0] mag;
			logic [3:0]    digit_q[$];
			logic          neg;
			char_word_t    w;
			neg = v[VW-1];
			// magnitude taken as unsigned, so the most negative value is exact
			mag = neg ? (~v + 1'b1) : v;
			do begin
				digit_q.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (neg) begin
				w.code = CH_MINUS;
				w.last = 1'b0;
				text_q = {text_q, w};
				seen_neg[digit_q.size()] = 1'b1;
			end else begin
				seen_pos[digit_q.size()] = 1'b1;
			end
			foreach (digit_q[i]) begin
				w.code = CH_ZERO + 8'(digit_q[i]);
				w.last = (i == digit_q.size() - 1);
				text_q = {text_q, w};
			end
			numbers_noted++;
		endfunction

		function void check_char(logic [7:0] code, logic lst);
			char_word_t w;
			chars_checked++;
			if (text_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected char %0d last %0d", $realtime, code, lst);
				return;
			end
			w = text_q.pop_front();
			if (w.code !== code || w.last !== lst) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: char mismatch: expected %0d last %0d, got %0d last %0d",
						$realtime, w.code, w.last, code, lst);
			end
		endfunction

		function int pending();
			return text_q.size();
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_stall;
	logic [VW-1:0] value;
	logic          out_valid;
	logic          out_stall;
	logic [7:0]    char_code;
	logic          last;

	ascii_scoreboard sb;
	bit              hold_now;
	int unsigned     idle_cycles;

	integer_to_decimal_ascii #(.VALUE_WIDTH(VW)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code),
		.last     (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// caller sits at a rising edge; returns at the edge where the word was taken
	task automatic send_value(input logic [VW-1:0] v);
		in_valid <= 1'b1;
		value    <= v;
		do @(posedge clk); while (in_stall);
		sb.note_value(v);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [VW-1:0] gen_value();
		int unsigned   kind;
		int unsigned   ndig;
		longint        lo;
		longint        hi;
		longint        mag;
		logic [VW-1:0] v;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			// spread over digit counts so short and long texts both show up
			ndig = $urandom_range(1, 10);
			lo = 1;
			repeat (ndig - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			if (ndig == 1)
				lo = 0;
			if (hi > 64'sd2147483647)
				hi = 64'sd2147483647;
			mag = lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1));
			v = mag[VW-1:0];
			if ($urandom_range(0, 1))
				v = -v;
		end else if (kind < 8) begin
			v = $urandom;
		end else if (kind == 8) begin
			if ($urandom_range(0, 1))
				v = 32'h8000_0000 + $urandom_range(0, 3);
			else
				v = 32'h7fff_ffff - $urandom_range(0, 3);
		end else begin
			v = 32'($urandom_range(0, 20)) - 32'd10;
		end
		return v;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_char(char_code, last);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("integer_to_decimal_ascii regression: fail");
				$finish;
			end
		end
	end

	// receiver back-pressure
	initial begin
		stall_mode_t mode;
		int unsigned phase_left;
		int unsigned hold_left;
		out_stall  = 1'b0;
		mode       = STALL_NONE;
		phase_left = 0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_now) begin
				hold_now  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (phase_left == 0) begin
					mode       = stall_mode_t'($urandom_range(0, 3));
					phase_left = $urandom_range(40, 200);
				end
				phase_left--;
				case (mode)
					STALL_NONE:   out_stall <= 1'b0;
					STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
					default:      out_stall <= ~out_stall;
				endcase
			end
		end
	end

	initial begin
		logic [VW-1:0] directed[] = '{
			32'd0, 32'd1, 32'hffff_ffff, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99,
			-32'd100, 32'd12345, -32'd67890, 32'd999999999, 32'd1000000000,
			-32'd1000000000, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000,
			32'h5555_5555, 32'haaaa_aaaa, 32'd1234567890
		};
		int unsigned burst_left;
		int unsigned gap;
		sb          = new;
		hold_now    = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		value       = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_value(directed[i]);
		drain();

		burst_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 100)
				hold_now = 1'b1;    // block fills and stalls its input meanwhile
			if (i == 200)
				drain();
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(0, 20);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			send_value(gen_value());
		end

		drain();
		repeat (60) @(posedge clk);

		if (sb.pending() != 0)
			$display("%0d characters never arrived", sb.pending());
		$display("run covered %0d numbers, %0d characters, %0d mismatches",
			sb.numbers_noted, sb.chars_checked, sb.mismatches);
		$display("digit counts seen: positive %b, negative %b (10 down to 1)",
			sb.seen_pos, sb.seen_neg);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("integer_to_decimal_ascii regression: pass");
		else
			$display("integer_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule
